// ----- sv/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: operation codes,
// status codes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package deq_pkg;

  // field widths
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // default capacity in words
  localparam int DEQ_DEPTH = 16;

  // word answered by a pop or dump of an empty queue
  localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DREQ,
    S_DDATA
  } state_t;

endpackage

// ----- sv/deq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if
// Valid/ready channels carrying queue operations in and result words out.
// ----------------------------------------------------------------------------
interface deq_in_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_res;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        count;
  logic                      last;

  modport source (output valid, output value_res, output status, output count,
                  output last, input ready);
  modport sink   (input valid, input value_res, input status, input count,
                  input last, output ready);
endinterface

// ----- sv/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words in a ring store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per word: kind (push back, push front,
//   pop front, pop back, dump) and the value to push.
//   rsp returns result words: value_res, status (ok, empty, full),
//   count after the operation and last on the final word of an operation.
// Timing:
//   push and any empty/full answer: result in the cycle after acceptance,
//   and a new operation may be taken every cycle while rsp.ready is high.
//   pop: the store read is registered, then the S_POP state loads the result.
//   dump: one store read per stored word, in S_DREQ and then S_DDATA.
//   req.ready is low while a pop or dump is in progress.
// Stall:
//   results sit in one output register; while it is held and rsp.ready is
//   low, req.ready stays low and a dump pauses before its next read.
// Reset:
//   rst clears head, fill and the output valid; the queue starts empty.
//   Store contents need no clearing, only written entries are read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  deq_in_if.sink     req,
  deq_out_if.source  rsp
);
  import deq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic                      wr_en;
  logic [PTR_W-1:0]          wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en;
  logic [PTR_W-1:0]          rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  deq_mem #(.DEPTH(DEPTH), .DATA_W(VALUE_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- sv/deq_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_mem
// Ring store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_mem #(
  parameter int DEPTH  = deq_pkg::DEQ_DEPTH,
  parameter int DATA_W = deq_pkg::VALUE_W
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic signed [DATA_W-1:0]         wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic signed [DATA_W-1:0]         rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/deq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Head pointer, fill count, operation sequencer and the output word register.
// ----------------------------------------------------------------------------
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  deq_in_if.sink                              req,
  deq_out_if.source                           rsp,
  output logic                                wr_en,
  output logic [$clog2(DEPTH)-1:0]            wr_addr,
  output logic signed [deq_pkg::VALUE_W-1:0]  wr_data,
  output logic                                rd_en,
  output logic [$clog2(DEPTH)-1:0]            rd_addr,
  input  logic signed [deq_pkg::VALUE_W-1:0]  rd_data
);
  import deq_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0]    DEPTH_P  = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_N   = FILL_W'(DEPTH);
  localparam logic [FILL_W-1:0] ONE_N    = FILL_W'(1);

  state_t state, state_next;

  logic [PTR_W-1:0]  head, head_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [FILL_W-1:0] didx, didx_next;

  // output word register
  logic                      ovalid;
  logic signed [VALUE_W-1:0] ovalue;
  status_t                   ostatus;
  logic [COUNT_W-1:0]        ocount;
  logic                      olast;

  logic                      load;
  logic signed [VALUE_W-1:0] load_value;
  status_t                   load_status;
  logic                      load_last;

  logic accept, out_free, empty, full, is_pop, is_dump, dump_last;

  // ring position offset entries from the head
  function automatic logic [PTR_W-1:0] ring(input logic [PTR_W-1:0] base,
                                            input logic [FILL_W-1:0] off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + (PTR_W + 1)'(off);
    if (s >= DEPTH_P) begin
      s = s - DEPTH_P;
    end
    return s[PTR_W-1:0];
  endfunction

  assign out_free  = !ovalid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign empty     = (fill == '0);
  assign full      = (fill == FULL_N);
  assign is_pop    = (req.kind == KIND_POP_FRONT) || (req.kind == KIND_POP_BACK);
  assign is_dump   = (req.kind == KIND_DUMP);
  assign dump_last = (didx == fill - ONE_N);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !empty && is_pop) begin
          state_next = S_POP;
        end else if (accept && !empty && is_dump) begin
          state_next = S_DREQ;
        end
      end
      S_POP:   state_next = S_IDLE;
      S_DREQ: begin
        if (out_free) begin
          state_next = S_DDATA;
        end
      end
      S_DDATA: state_next = dump_last ? S_IDLE : S_DREQ;
      default: state_next = S_IDLE;
    endcase
  end

  // pointer updates, memory accesses and result loads
  always_comb begin
    req.ready   = (state == S_IDLE) && out_free;
    head_next   = head;
    fill_next   = fill;
    didx_next   = didx;
    wr_en       = 1'b0;
    wr_addr     = head;
    wr_data     = req.value;
    rd_en       = 1'b0;
    rd_addr     = head;
    load        = 1'b0;
    load_value  = '0;
    load_status = ST_OK;
    load_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.kind) inside
            KIND_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                load_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ring(head, fill);
                fill_next = fill + ONE_N;
              end
            end
            KIND_PUSH_FRONT: begin
              load = 1'b1;
              if (full) begin
                load_status = ST_FULL;
              end else begin
                head_next = (head == '0) ? LAST_IDX : head - PTR_W'(1);
                wr_en     = 1'b1;
                wr_addr   = head_next;
                fill_next = fill + ONE_N;
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK, KIND_DUMP: begin
              if (empty) begin
                load        = 1'b1;
                load_value  = INT_MIN;
                load_status = ST_EMPTY;
              end else if (req.kind == KIND_POP_FRONT) begin
                rd_en     = 1'b1;
                rd_addr   = head;
                head_next = (head == LAST_IDX) ? '0 : head + PTR_W'(1);
                fill_next = fill - ONE_N;
              end else if (req.kind == KIND_POP_BACK) begin
                rd_en     = 1'b1;
                rd_addr   = ring(head, fill - ONE_N);
                fill_next = fill - ONE_N;
              end else begin
                didx_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        load       = 1'b1;
        load_value = rd_data;
      end
      S_DREQ: begin
        if (out_free) begin
          rd_en   = 1'b1;
          rd_addr = ring(head, didx);
        end
      end
      S_DDATA: begin
        load       = 1'b1;
        load_value = rd_data;
        load_last  = dump_last;
        didx_next  = didx + ONE_N;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      fill   <= '0;
      didx   <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      didx  <= didx_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      ovalue  <= load_value;
      ostatus <= load_status;
      ocount  <= COUNT_W'(fill_next);
      olast   <= load_last;
    end
  end

  assign rsp.valid     = ovalid;
  assign rsp.value_res = ovalue;
  assign rsp.status    = ostatus;
  assign rsp.count     = ocount;
  assign rsp.last      = olast;

  // fill never passes the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_N)
    else $error("fill count above capacity");

  // a held word is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load && ovalid |-> rsp.ready)
    else $error("output word overwritten");

  // every memory read is consumed in the following cycle
  a_read_used: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_POP) || (state == S_DDATA))
    else $error("read data not consumed");

  // no operation taken while a pop or dump is in progress
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready)
    else $error("operation accepted while busy");

  // no write and read of the store in the same cycle
  a_no_rw: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("store read and written together");

endmodule

// ----- tb/double_ended_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded double-ended queue. Directed tests
// cover the empty queue, extreme words, the full queue and ignored kinds.
// A phased random run then grows and shrinks the queue so that it passes
// through empty and full many times. A shadow deque predicts every result
// word, and a checker compares each accepted word with the oldest one
// predicted. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int QDEPTH      = DEQ_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_OPS    = 130;

  // one predicted result word
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } deq_result_t;

  logic clk;
  logic rst;

  deq_in_if  req_ch ();
  deq_out_if rsp_ch ();

  double_ended_queue #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow copy of the queue
  logic signed [VALUE_W-1:0] shadow_words [QDEPTH];
  int                        shadow_head;
  int                        shadow_fill;

  deq_result_t pending_results [$];
  deq_result_t seen_word;
  int          mismatches;
  int          cycles;
  bit          steady;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 9);
  end

  // queue one predicted result word
  function automatic void expect_word(logic signed [VALUE_W-1:0] value_res,
                                      status_t status, logic last);
    deq_result_t w;
    w.value_res = value_res;
    w.status    = status;
    w.count     = shadow_fill[COUNT_W-1:0];
    w.last      = last;
    pending_results.push_back(w);
  endfunction

  // advance the shadow deque by one operation
  function automatic void predict_op(logic [KIND_W-1:0] kind,
                                     logic signed [VALUE_W-1:0] value);
    logic signed [VALUE_W-1:0] got;
    case (kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (shadow_fill >= QDEPTH) begin
          expect_word('0, ST_FULL, 1'b1);
        end else begin
          if (kind == KIND_PUSH_BACK) begin
            shadow_words[(shadow_head + shadow_fill) % QDEPTH] = value;
          end else begin
            shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
            shadow_words[shadow_head] = value;
          end
          shadow_fill++;
          expect_word('0, ST_OK, 1'b1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (shadow_fill == 0) begin
          expect_word(INT_MIN, ST_EMPTY, 1'b1);
        end else begin
          if (kind == KIND_POP_FRONT) begin
            got = shadow_words[shadow_head];
            shadow_head = (shadow_head + 1) % QDEPTH;
          end else begin
            got = shadow_words[(shadow_head + shadow_fill - 1) % QDEPTH];
          end
          shadow_fill--;
          expect_word(got, ST_OK, 1'b1);
        end
      end
      KIND_DUMP: begin
        if (shadow_fill == 0) begin
          expect_word(INT_MIN, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++) begin
            expect_word(shadow_words[(shadow_head + i) % QDEPTH], ST_OK,
                        i == shadow_fill - 1);
          end
        end
      end
      // unused kinds are ignored
      default: ;
    endcase
  endfunction

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: value_res=%0d status=%0d count=%0d last=%0b",
                   rsp_ch.value_res, rsp_ch.status, rsp_ch.count, rsp_ch.last);
        end
      end else begin
        seen_word = pending_results.pop_front();
        if (rsp_ch.value_res !== seen_word.value_res ||
            rsp_ch.status !== seen_word.status ||
            rsp_ch.count !== seen_word.count ||
            rsp_ch.last !== seen_word.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected value_res=%0d status=%0d count=%0d last=%0b",
                     seen_word.value_res, seen_word.status, seen_word.count,
                     seen_word.last);
            $display("          actual   value_res=%0d status=%0d count=%0d last=%0b",
                     rsp_ch.value_res, rsp_ch.status, rsp_ch.count, rsp_ch.last);
          end
        end
      end
    end
  end

  // send one operation word, with a random idle gap ahead of it
  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic signed [VALUE_W-1:0] value);
    while (!steady && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_op(kind, value);
    @(negedge clk);
  endtask

  // word mix leaning on the extremes
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return INT_MIN;
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // pops and dump of an empty queue, then the unused kinds
  task automatic test_empty_queue();
    send_op(KIND_POP_FRONT, $urandom);
    send_op(KIND_POP_BACK, $urandom);
    send_op(KIND_DUMP, $urandom);
    send_op(3'd5, $urandom);
    send_op(3'd7, $urandom);
  endtask

  // extreme words through both ends, last pop removes the sole word
  task automatic test_extreme_words();
    send_op(KIND_PUSH_BACK, INT_MIN);
    send_op(KIND_PUSH_FRONT, {1'b0, {(VALUE_W-1){1'b1}}});
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_FRONT, '1);
  endtask

  // fill to capacity, refused pushes at both ends, dump a full queue
  task automatic test_full_queue();
    for (int i = 0; i < QDEPTH; i++) begin
      send_op(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom);
    end
    send_op(KIND_PUSH_BACK, $urandom);
    send_op(KIND_PUSH_FRONT, $urandom);
    send_op(KIND_DUMP, '0);
  endtask

  // phased random traffic: growing and shrinking stretches
  task automatic test_random_traffic();
    int          roll;
    int          push_pct;
    logic [KIND_W-1:0] kind;
    int          done_ops;
    done_ops = 0;
    push_pct = 30;
    while (done_ops < RAND_OPS) begin
      if (done_ops % 24 == 0) push_pct = (push_pct == 30) ? 62 : 30;
      // long stretch with no idling on either side
      steady = (done_ops >= 60 && done_ops < 100);
      roll = $urandom_range(99);
      if (roll < 3) begin
        kind = KIND_W'(5 + $urandom_range(2));
      end else if (roll < 12) begin
        kind = KIND_DUMP;
        done_ops++;
      end else if (roll < 12 + push_pct) begin
        kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        done_ops++;
      end else begin
        kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
        done_ops++;
      end
      send_op(kind, pick_word());
    end
    steady = 1'b0;
  endtask

  // stimulus, drain and verdict
  initial begin
    rst          = 1'b1;
    steady       = 1'b0;
    mismatches   = 0;
    cycles       = 0;
    shadow_head  = 0;
    shadow_fill  = 0;
    req_ch.valid = 1'b0;
    req_ch.kind  = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_queue();
    test_extreme_words();
    test_full_queue();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_mem.sv
sv/deq_ctrl.sv
sv/double_ended_queue.sv
tb/double_ended_queue_tb.sv
